[sv/focd_pkg.sv]
// Shared constants, types and codes for the framed occupancy change detector.
`timescale 1ns / 1ps

package focd_pkg;

   localparam int DATA_BYTES = 8;
   localparam int BYTE_W     = 8;
   localparam int BOARD_W    = 64;
   localparam int SQ_W       = 6;
   localparam int KIND_W     = 2;
   localparam int CNT_W      = 4;
   localparam int IDLE_W     = 16;
   localparam int FB_IDX_W   = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_START_MARKER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_MARKER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET  = 8'd0;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET    = 8'd255;
   localparam logic [IDLE_W-1:0] TIMEOUT_TICKS_RESET = 16'd1000;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHANGE  = 2'd0,
      KIND_SAME    = 2'd1,
      KIND_BAD_END = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_DATA = 3'b010,
      PH_END  = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'b01,
      CTL_SCAN = 2'b10
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single;
      logic multi;
      logic scan_last;
   } status_type;

endpackage

[sv/focd_req_if.sv]
// Input channel: received bytes and time ticks.
`timescale 1ns / 1ps

interface focd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [focd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

[sv/focd_rsp_if.sv]
// Result channel: square changes and frame status words.
`timescale 1ns / 1ps

interface focd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [focd_pkg::KIND_W-1:0]  kind;
   logic [focd_pkg::SQ_W-1:0]    square;
   logic                         placed;
   logic                         last;
   logic [focd_pkg::BOARD_W-1:0] occupancy;

   modport source (output valid, output kind, output square, output placed,
                   output last, output occupancy, input ready);
   modport sink   (input valid, input kind, input square, input placed,
                   input last, input occupancy, output ready);
endinterface

[sv/framed_occupancy_change_detector_core.sv]
// Top level of the framed occupancy change detector.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    action, rx_byte
//   rsp_chan  out        valid / ready    kind, square, placed, last, occupancy
//   csr_*     in         csr_wr_en only   csr_index, csr_data
//
// A tick or byte word is taken outside a burst when the result register is free
// or being emptied; a word that gives one result shows it on the next cycle.
// A good frame with N changed squares emits N results, one per cycle unless
// stalled, by the lowest-set-bit unit; input waits until the last is loaded.
// Reset is synchronous; it restores the register defaults and an empty board.
// A stalled result holds its register and stalls input behind it.
`timescale 1ns / 1ps

module framed_occupancy_change_detector_core (
   input  logic                            clock,
   input  logic                            reset,
   focd_req_if.sink                        req_chan,
   focd_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [focd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [focd_pkg::CSR_DATA_W-1:0] csr_data
);
   import focd_pkg::*;

   cmd_type    cmd;
   status_type status;

   focd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   focd_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_action    (req_chan.action),
      .req_rx_byte   (req_chan.rx_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_kind      (rsp_chan.kind),
      .rsp_square    (rsp_chan.square),
      .rsp_placed    (rsp_chan.placed),
      .rsp_last      (rsp_chan.last),
      .rsp_occupancy (rsp_chan.occupancy)
   );

endmodule

[sv/focd_ctrl.sv]
// Controller: input acceptance, change-burst sequencing and result valid.
`timescale 1ns / 1ps

module focd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  focd_pkg::status_type status,
   output focd_pkg::cmd_type    cmd
);
   import focd_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == CTL_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.accept    = accept;
   assign cmd.scan_step = (state_ff == CTL_SCAN) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (out_free) begin
               rsp_valid_in = accept && status.single;
            end
            if (accept && status.multi) begin
               state_in = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            // one change word per free output slot
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (status.scan_last) begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: begin
            state_in     = CTL_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/focd_dpath.sv]
// Datapath: configuration, frame receiver state, board compare and result register.
`timescale 1ns / 1ps

module focd_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [focd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [focd_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_action,
   input  logic [focd_pkg::BYTE_W-1:0]     req_rx_byte,
   input  focd_pkg::cmd_type              cmd,
   output focd_pkg::status_type           status,
   output logic [focd_pkg::KIND_W-1:0]     rsp_kind,
   output logic [focd_pkg::SQ_W-1:0]       rsp_square,
   output logic                           rsp_placed,
   output logic                           rsp_last,
   output logic [focd_pkg::BOARD_W-1:0]    rsp_occupancy
);
   import focd_pkg::*;

   logic [BYTE_W-1:0]  start_marker_ff;
   logic [BYTE_W-1:0]  end_marker_ff;
   logic [IDLE_W-1:0]  timeout_ff;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;
   logic [BYTE_W-1:0]  frame_ff [DATA_BYTES];
   logic [BOARD_W-1:0] prior_ff;
   logic [BOARD_W-1:0] diff_ff;
   logic [BOARD_W-1:0] word_ff;

   logic [KIND_W-1:0]  kind_ff;
   logic [SQ_W-1:0]    square_ff;
   logic               placed_ff;
   logic               last_ff;
   logic [BOARD_W-1:0] occ_ff;

   logic [BOARD_W-1:0] word;
   logic [BOARD_W-1:0] diff_new;
   logic [BOARD_W-1:0] low_bit;
   logic [BOARD_W-1:0] diff_rest;
   logic [SQ_W-1:0]    low_sq;
   logic               single;
   logic               multi;
   kind_type           single_kind;
   logic [BOARD_W-1:0] single_occ;
   logic [CNT_W-1:0]   cnt_next;
   logic               store_byte;

   // bytes past the frame length read as zero
   always_comb begin
      word = '0;
      for (int i = 0; i < DATA_BYTES; i++) begin
         word[i*BYTE_W +: BYTE_W] = frame_ff[i];
      end
   end

   assign diff_new = word ^ prior_ff;

   // isolate and encode the lowest pending change
   assign low_bit   = diff_ff & (~diff_ff + BOARD_W'(1));
   assign diff_rest = diff_ff & ~low_bit;

   always_comb begin
      low_sq = '0;
      for (int i = 0; i < BOARD_W; i++) begin
         if (low_bit[i]) begin
            low_sq = low_sq | SQ_W'(i);
         end
      end
   end

   assign cnt_next = byte_cnt_ff + CNT_W'(1);

   always_comb begin
      single      = 1'b0;
      multi       = 1'b0;
      single_kind = KIND_TIMEOUT;
      single_occ  = '0;
      phase_in    = phase_ff;
      byte_cnt_in = byte_cnt_ff;
      idle_in     = idle_ff;
      store_byte  = 1'b0;
      if (req_action) begin
         if (phase_ff != PH_WAIT) begin
            if (idle_ff >= timeout_ff) begin
               single      = 1'b1;
               single_kind = KIND_TIMEOUT;
               phase_in    = PH_WAIT;
               byte_cnt_in = '0;
               idle_in     = '0;
            end else begin
               idle_in = idle_ff + IDLE_W'(1);
            end
         end
      end else begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (req_rx_byte == start_marker_ff) begin
                  phase_in    = PH_DATA;
                  byte_cnt_in = '0;
                  idle_in     = '0;
               end
            end
            PH_DATA: begin
               store_byte  = 1'b1;
               byte_cnt_in = cnt_next;
               idle_in     = '0;
               if (32'(cnt_next) >= DATA_BYTES) begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               phase_in    = PH_WAIT;
               byte_cnt_in = '0;
               idle_in     = '0;
               if (req_rx_byte != end_marker_ff) begin
                  single      = 1'b1;
                  single_kind = KIND_BAD_END;
               end else if (diff_new == '0) begin
                  single      = 1'b1;
                  single_kind = KIND_SAME;
                  single_occ  = word;
               end else begin
                  multi = 1'b1;
               end
            end
            default: begin
               phase_in    = PH_WAIT;
               byte_cnt_in = '0;
               idle_in     = '0;
            end
         endcase
      end
   end

   assign status.single    = single;
   assign status.multi     = multi;
   assign status.scan_last = (diff_rest == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
         timeout_ff      <= TIMEOUT_TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_START_MARKER:  start_marker_ff <= csr_data[BYTE_W-1:0];
            REG_END_MARKER:    end_marker_ff   <= csr_data[BYTE_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ff      <= csr_data[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         byte_cnt_ff <= '0;
         idle_ff     <= '0;
         prior_ff    <= '0;
      end else if (cmd.accept) begin
         phase_ff    <= phase_in;
         byte_cnt_ff <= byte_cnt_in;
         idle_ff     <= idle_in;
         if (multi) begin
            prior_ff <= word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && store_byte) begin
         frame_ff[byte_cnt_ff[FB_IDX_W-1:0]] <= req_rx_byte;
      end
      if (cmd.accept && multi) begin
         diff_ff <= diff_new;
         word_ff <= word;
      end else if (cmd.scan_step) begin
         diff_ff <= diff_rest;
      end
      // result payload
      if (cmd.accept && single) begin
         kind_ff   <= single_kind;
         square_ff <= '0;
         placed_ff <= 1'b0;
         last_ff   <= 1'b1;
         occ_ff    <= single_occ;
      end else if (cmd.scan_step) begin
         kind_ff   <= KIND_CHANGE;
         square_ff <= low_sq;
         placed_ff <= |(word_ff & low_bit);
         last_ff   <= (diff_rest == '0);
         occ_ff    <= word_ff;
      end
   end

   assign rsp_kind      = kind_ff;
   assign rsp_square    = square_ff;
   assign rsp_placed    = placed_ff;
   assign rsp_last      = last_ff;
   assign rsp_occupancy = occ_ff;

endmodule
